[sv/sirs_pkg.sv]
// Shared types, register addresses and reset tables of the SPI register slave.
// Depends on nothing; every other file but sirs_channels imports it.
`default_nettype none

package sirs_pkg;

    localparam int REG_COUNT    = 128;
    localparam int SAMPLE_BYTES = 14;
    localparam int ADDR_W       = $clog2(REG_COUNT);
    localparam int IDX_W        = 4;

    localparam logic [ADDR_W-1:0] A_FIFO_EN   = 7'h23;
    localparam logic [ADDR_W-1:0] A_STATUS    = 7'h3A;
    localparam logic [ADDR_W-1:0] A_SAMPLE    = 7'h3B;
    localparam logic [ADDR_W-1:0] A_TEMP      = 7'h41;
    localparam logic [ADDR_W-1:0] A_GYRO      = 7'h43;
    localparam logic [ADDR_W-1:0] A_USER      = 7'h6A;
    localparam logic [ADDR_W-1:0] A_POWER     = 7'h6B;
    localparam logic [ADDR_W-1:0] A_CNT_H     = 7'h72;
    localparam logic [ADDR_W-1:0] A_CNT_L     = 7'h73;
    localparam logic [ADDR_W-1:0] A_FIFO_DATA = 7'h74;
    localparam logic [ADDR_W-1:0] A_IDENT     = 7'h75;
    localparam logic [ADDR_W-1:0] A_SAMPLE_LAST =
        ADDR_W'(int'(A_SAMPLE) + SAMPLE_BYTES - 1);

    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] IDENT_VAL   = 8'h12;
    localparam logic [7:0] POWER_VAL   = 8'h40;
    localparam logic [7:0] STATUS_VAL  = 8'h01;
    localparam logic [7:0] SAMPLE_CNT  = 8'(SAMPLE_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_BYTES);

    localparam int READ_BIT       = 7;
    localparam int POWER_RST_BIT  = 7;
    localparam int USER_FIFO_BIT  = 6;
    localparam int USER_FRST_BIT  = 2;

    typedef struct packed {
        logic cs_change;
        logic idle_answer;
        logic command;
        logic write;
        logic read_start;
        logic read_finish;
    } sirs_cmd_t;

    typedef struct packed {
        logic selected;
        logic awaiting;
        logic reading;
    } sirs_status_t;

    function automatic logic [7:0] sample_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] v;
        case (idx)
            4'd4:    v = 8'h40;
            4'd6:    v = 8'h01;
            4'd7:    v = 8'h2C;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] reset_value(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] off;
        logic [7:0]        v;
        off = a - A_SAMPLE;
        if (a == A_IDENT)
            v = IDENT_VAL;
        else if (a == A_POWER)
            v = POWER_VAL;
        else if (a == A_STATUS)
            v = STATUS_VAL;
        else if (a inside {[A_SAMPLE:A_SAMPLE_LAST]})
            v = sample_byte(off[IDX_W-1:0]);
        else
            v = 8'h00;
        return v;
    endfunction

    function automatic logic [REG_COUNT-1:0] sample_mask();
        logic [REG_COUNT-1:0] m;
        m = '0;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            if (i >= int'(A_SAMPLE) && i <= int'(A_SAMPLE_LAST))
                m[i] = 1'b1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[sv/sirs_channels.sv]
// Valid/ready channel interfaces of the SPI register slave: byte events in,
// answer bytes out. No dependencies.
`default_nettype none

interface sirs_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] mosi_byte;
    logic       cs_level;

    modport source (output valid, output func, output mosi_byte, output cs_level,
                    input ready);
    modport sink   (input valid, input func, input mosi_byte, input cs_level,
                    output ready);
endinterface

interface sirs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] miso_byte;

    modport source (output valid, output miso_byte, input ready);
    modport sink   (input valid, input miso_byte, output ready);
endinterface

`default_nettype wire

[sv/spi_imu_register_slave.sv]
// Top level of the SPI register slave: controller plus datapath.
// Depends on sirs_pkg, sirs_channels, sirs_ctrl and sirs_datapath.
//
// Each host transaction is a chip-select change (func = 1) or one SPI byte
// (func = 0). A chip-select change gives no answer.
// A byte gives exactly one answer on reply: command, write and deselected
// bytes answer 0xFF in the cycle after acceptance; register reads pass
// through the ST_READ state first, for the registered read port of the
// 128-byte register file. One byte is in flight at a time: host is ready
// again in the cycle after the answer is taken. After reset, and after a
// power-register reset write, every register reads its reset value until
// written.
`default_nettype none

module spi_imu_register_slave
    import sirs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sirs_in_if.sink   host,
    sirs_out_if.source reply
);

    sirs_cmd_t    cmd;
    sirs_status_t status;

    sirs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (host.valid),
        .in_ready  (host.ready),
        .in_func   (host.func),
        .out_valid (reply.valid),
        .out_ready (reply.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sirs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mosi_byte (host.mosi_byte),
        .cs_level  (host.cs_level),
        .status    (status),
        .miso_byte (reply.miso_byte)
    );

endmodule

`default_nettype wire

[sv/sirs_ctrl.sv]
// Sequencing state machine of the SPI register slave: handshakes and commands.
// Depends on sirs_pkg.
`default_nettype none

module sirs_ctrl
    import sirs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic         in_func,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire sirs_status_t status,
    output sirs_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func)
                        cmd.cs_change = 1'b1;
                    else if (!status.selected)
                    begin
                        cmd.idle_answer = 1'b1;
                        state_next      = ST_OUT;
                    end
                    else if (status.awaiting)
                    begin
                        cmd.command = 1'b1;
                        state_next  = ST_OUT;
                    end
                    else if (status.reading)
                    begin
                        cmd.read_start = 1'b1;
                        state_next     = ST_READ;
                    end
                    else
                    begin
                        cmd.write  = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read_finish = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[sv/sirs_datapath.sv]
// Register file, address pointer, FIFO position and answer register of the
// SPI register slave. Depends on sirs_pkg; driven by sirs_ctrl commands.
`default_nettype none

module sirs_datapath
    import sirs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire sirs_cmd_t  cmd,
    input  wire logic [7:0] mosi_byte,
    input  wire logic       cs_level,
    output sirs_status_t    status,
    output logic [7:0]      miso_byte
);

    localparam logic [REG_COUNT-1:0] SAMPLE_MASK = sample_mask();

    logic [7:0]           mem [REG_COUNT];
    logic [7:0]           rdata_reg;
    logic [7:0]           miso_reg;
    logic [7:0]           miso_next;
    logic [REG_COUNT-1:0] valid_reg;
    logic [REG_COUNT-1:0] valid_next;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    addr_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic                 awaiting_reg;
    logic                 awaiting_next;
    logic                 reading_reg;
    logic                 reading_next;
    logic                 selected_reg;
    logic                 selected_next;
    logic                 fifo_en_reg;
    logic                 fifo_en_next;
    logic                 user_fifo_reg;
    logic                 user_fifo_next;

    logic                 fifo_on;
    logic                 power_rst;
    logic                 store;
    logic                 refresh;
    logic                 pre_refresh;
    logic [IDX_W-1:0]     idx_eff;
    logic [ADDR_W-1:0]    addr_adv;

    assign fifo_on   = fifo_en_reg || user_fifo_reg;
    assign power_rst = (addr_reg == A_POWER) && mosi_byte[POWER_RST_BIT];
    assign store     = cmd.write && !power_rst;
    assign addr_adv  = (addr_reg == A_FIFO_DATA) ? addr_reg : addr_reg + ADDR_W'(1);
    assign idx_eff   = (idx_reg >= LAST_IDX) ? '0 : idx_reg;
    assign pre_refresh = (addr_reg == A_SAMPLE) || (addr_reg == A_TEMP) ||
                         (addr_reg == A_GYRO);

    always_comb
    begin
        valid_next     = valid_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        awaiting_next  = awaiting_reg;
        reading_next   = reading_reg;
        selected_next  = selected_reg;
        fifo_en_next   = fifo_en_reg;
        user_fifo_next = user_fifo_reg;
        miso_next      = miso_reg;
        refresh        = 1'b0;

        if (cmd.cs_change)
        begin
            selected_next = !cs_level;
            awaiting_next = 1'b1;
            reading_next  = 1'b0;
            addr_next     = '0;
        end

        if (cmd.idle_answer)
            miso_next = IDLE_BYTE;

        if (cmd.command)
        begin
            reading_next  = mosi_byte[READ_BIT];
            addr_next     = mosi_byte[ADDR_W-1:0];
            awaiting_next = 1'b0;
            miso_next     = IDLE_BYTE;
        end

        if (cmd.write)
        begin
            miso_next = IDLE_BYTE;
            if (power_rst)
            begin
                valid_next     = '0;
                idx_next       = '0;
                fifo_en_next   = 1'b0;
                user_fifo_next = 1'b0;
                awaiting_next  = 1'b0;
                reading_next   = 1'b0;
                addr_next      = ADDR_W'(1);
            end
            else
            begin
                valid_next[addr_reg] = 1'b1;
                addr_next            = addr_adv;
                if (addr_reg == A_FIFO_EN)
                    fifo_en_next = (mosi_byte != 8'h00);
                if (addr_reg == A_USER)
                begin
                    user_fifo_next = mosi_byte[USER_FIFO_BIT];
                    if (mosi_byte[USER_FRST_BIT])
                    begin
                        idx_next = '0;
                        refresh  = 1'b1;
                    end
                end
            end
        end

        if (cmd.read_finish)
        begin
            addr_next = addr_adv;
            case (addr_reg)
                A_STATUS:
                begin
                    miso_next = STATUS_VAL;
                    refresh   = 1'b1;
                end
                A_CNT_H:
                begin
                    miso_next = 8'h00;
                    if (fifo_on)
                    begin
                        refresh  = 1'b1;
                        idx_next = '0;
                    end
                end
                A_CNT_L:
                begin
                    miso_next = fifo_on ? SAMPLE_CNT : 8'h00;
                end
                A_FIFO_DATA:
                begin
                    if (!fifo_on)
                        miso_next = 8'h00;
                    else
                    begin
                        refresh   = (idx_reg >= LAST_IDX);
                        miso_next = sample_byte(idx_eff);
                        idx_next  = idx_eff + IDX_W'(1);
                    end
                end
                default:
                begin
                    refresh = pre_refresh;
                    if (pre_refresh || !valid_reg[addr_reg])
                        miso_next = reset_value(addr_reg);
                    else
                        miso_next = rdata_reg;
                end
            endcase
        end

        if (refresh)
            valid_next = valid_next & ~SAMPLE_MASK;
    end

    always_ff @(posedge clk)
    begin
        if (store)
            mem[addr_reg] <= mosi_byte;
        if (cmd.read_start)
            rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        miso_reg <= miso_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            addr_reg      <= '0;
            idx_reg       <= '0;
            awaiting_reg  <= 1'b1;
            reading_reg   <= 1'b0;
            selected_reg  <= 1'b0;
            fifo_en_reg   <= 1'b0;
            user_fifo_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            addr_reg      <= addr_next;
            idx_reg       <= idx_next;
            awaiting_reg  <= awaiting_next;
            reading_reg   <= reading_next;
            selected_reg  <= selected_next;
            fifo_en_reg   <= fifo_en_next;
            user_fifo_reg <= user_fifo_next;
        end
    end

    assign status.selected = selected_reg;
    assign status.awaiting = awaiting_reg;
    assign status.reading  = reading_reg;
    assign miso_byte       = miso_reg;

endmodule

`default_nettype wire

[sim/spi_imu_register_slave_test.sv]
// Self-checking testbench of spi_imu_register_slave: drives SPI byte and chip-select
// transactions, predicts every answer byte and checks it on the reply channel.
// Depends on sirs_pkg, sirs_channels and the spi_imu_register_slave RTL.
`default_nettype none

module spi_imu_register_slave_test;
    import sirs_pkg::*;

    localparam int ITEM_TARGET = 1650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 33;

    class register_map_model;
        logic [7:0]        regs [REG_COUNT];
        logic [7:0]        burst [SAMPLE_BYTES];
        logic [ADDR_W-1:0] ptr;
        logic [IDX_W-1:0]  burst_idx;
        bit                awaiting_cmd;
        bit                read_mode;
        bit                chip_sel;
        logic [7:0]        miso_pending [$];
        int                errors;
        int                answers_seen;
        int                power_resets;
        int                byte_count;
        int                cs_count;

        function new();
            burst = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h01, 8'h2C,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            restore_file();
            ptr          = '0;
            awaiting_cmd = 1'b1;
            read_mode    = 1'b0;
            chip_sel     = 1'b0;
            errors       = 0;
            answers_seen = 0;
            power_resets = 0;
            byte_count   = 0;
            cs_count     = 0;
        endfunction

        function void refresh_burst();
            for (int i = 0; i < SAMPLE_BYTES; i++)
                regs[int'(A_SAMPLE) + i] = burst[i];
        endfunction

        function void restore_file();
            for (int i = 0; i < REG_COUNT; i++)
                regs[i] = 8'h00;
            regs[A_IDENT]  = IDENT_VAL;
            regs[A_POWER]  = POWER_VAL;
            regs[A_STATUS] = STATUS_VAL;
            burst_idx = '0;
            refresh_burst();
        endfunction

        function bit fifo_enabled();
            return regs[A_FIFO_EN] != 8'h00 || regs[A_USER][USER_FIFO_BIT];
        endfunction

        function logic [7:0] read_reg(input logic [ADDR_W-1:0] a);
            logic [7:0] v;
            case (a)
                A_STATUS:
                begin
                    refresh_burst();
                    v = STATUS_VAL;
                end
                A_CNT_H:
                begin
                    if (fifo_enabled())
                    begin
                        refresh_burst();
                        burst_idx = '0;
                    end
                    v = 8'h00;
                end
                A_CNT_L:
                    v = fifo_enabled() ? SAMPLE_CNT : 8'h00;
                A_FIFO_DATA:
                begin
                    if (!fifo_enabled())
                        v = 8'h00;
                    else
                    begin
                        if (burst_idx >= LAST_IDX)
                        begin
                            burst_idx = '0;
                            refresh_burst();
                        end
                        v = burst[burst_idx];
                        burst_idx = burst_idx + IDX_W'(1);
                    end
                end
                default:
                begin
                    if (a == A_SAMPLE || a == A_TEMP || a == A_GYRO)
                        refresh_burst();
                    v = regs[a];
                end
            endcase
            return v;
        endfunction

        function void write_reg(input logic [ADDR_W-1:0] a, input logic [7:0] v);
            if (a == A_POWER && v[POWER_RST_BIT])
            begin
                restore_file();
                awaiting_cmd = 1'b0;
                read_mode    = 1'b0;
                ptr          = '0;
                power_resets++;
            end
            else
            begin
                regs[a] = v;
                if (a == A_USER && v[USER_FRST_BIT])
                begin
                    burst_idx = '0;
                    refresh_burst();
                end
            end
        endfunction

        function void step_ptr();
            if (ptr != A_FIFO_DATA)
                ptr = ptr + ADDR_W'(1);
        endfunction

        function void take_event(input logic f, input logic [7:0] b, input logic c);
            logic [7:0] r;
            r = IDLE_BYTE;
            if (f)
            begin
                cs_count++;
                chip_sel     = !c;
                awaiting_cmd = 1'b1;
                read_mode    = 1'b0;
                ptr          = '0;
                return;
            end
            byte_count++;
            if (chip_sel)
            begin
                if (awaiting_cmd)
                begin
                    read_mode    = b[READ_BIT];
                    ptr          = b[ADDR_W-1:0];
                    awaiting_cmd = 1'b0;
                end
                else if (read_mode)
                begin
                    r = read_reg(ptr);
                    step_ptr();
                end
                else
                begin
                    write_reg(ptr, b);
                    step_ptr();
                end
            end
            miso_pending.push_back(r);
        endfunction

        function void match_answer(input logic [7:0] actual);
            logic [7:0] want;
            if (miso_pending.size() == 0)
            begin
                $display("%0t: unexpected answer, expected none, got %02h", $time, actual);
                errors++;
                return;
            end
            want = miso_pending.pop_front();
            answers_seen++;
            if (actual !== want)
            begin
                $display("%0t: miso_byte mismatch, expected %02h, got %02h",
                         $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   gaps_on;
    int   sent;
    int   cycle_count;

    register_map_model model = new();

    logic [ADDR_W-1:0] hot_addr [16] = '{A_FIFO_EN, A_STATUS, A_SAMPLE, A_TEMP, A_GYRO,
                                          A_USER, A_POWER, A_CNT_H, A_CNT_L, A_FIFO_DATA,
                                          A_IDENT, A_SAMPLE_LAST, 7'h7E, 7'h7F, 7'h00,
                                          7'h71};

    sirs_in_if  host ();
    sirs_out_if reply ();

    spi_imu_register_slave dut (
        .clk   (clk),
        .rst_n (rst_n),
        .host  (host),
        .reply (reply)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk)
    begin
        if (rst_n && reply.valid && reply.ready)
            model.match_answer(reply.miso_byte);
        reply.ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic put_event(input logic f, input logic [7:0] b, input logic c);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            host.valid <= 1'b0;
            @(posedge clk);
        end
        host.valid     <= 1'b1;
        host.func      <= f;
        host.mosi_byte <= b;
        host.cs_level  <= c;
        @(posedge clk);
        while (!host.ready)
            @(posedge clk);
        model.take_event(f, b, c);
        sent++;
    endtask

    task automatic cs_select();
        put_event(1'b1, 8'($urandom), 1'b0);
    endtask

    task automatic cs_release();
        put_event(1'b1, 8'($urandom), 1'b1);
    endtask

    task automatic spi_byte(input logic [7:0] b);
        put_event(1'b0, b, 1'($urandom));
    endtask

    task automatic drain_answers();
        host.valid <= 1'b0;
        while (model.miso_pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_session(input bit rd, input logic [ADDR_W-1:0] a, input int n);
        cs_select();
        spi_byte({rd, a});
        repeat (n) spi_byte(8'($urandom));
    endtask

    initial
    begin
        int unsigned      pick;
        int               n;
        bit               paused;
        logic [ADDR_W-1:0] a;

        paused         = 1'b0;
        sent           = 0;
        gaps_on        = 1'b1;
        rst_n          <= 1'b0;
        host.valid     <= 1'b0;
        host.func      <= 1'b0;
        host.mosi_byte <= 8'h00;
        host.cs_level  <= 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // deselected bytes, identity read, FIFO enable and readout
        spi_byte(8'h00);
        spi_byte(8'hFF);
        cs_select();
        spi_byte({1'b1, A_IDENT});
        spi_byte(8'h00);
        spi_byte(8'hFF);
        cs_select();
        spi_byte({1'b0, A_FIFO_EN});
        spi_byte(8'hFF);
        spi_byte(8'h00);
        cs_select();
        spi_byte({1'b1, A_CNT_H});
        repeat (4) spi_byte(8'h55);
        cs_release();
        // power reset write, then the follow-on write at address one
        cs_select();
        spi_byte({1'b0, A_POWER});
        spi_byte(8'h80);
        spi_byte(8'h5A);
        cs_select();
        spi_byte({1'b1, A_STATUS});
        spi_byte(8'hAA);
        spi_byte(8'h00);
        cs_release();

        while (sent < ITEM_TARGET)
        begin
            gaps_on = !(sent >= 700 && sent < 1000);
            if (!paused && sent >= 400)
            begin
                paused = 1'b1;
                drain_answers();
            end
            pick = $urandom_range(0, 99);
            if (pick < 88)
            begin
                a = ($urandom_range(0, 1) == 0) ? hot_addr[$urandom_range(0, 15)]
                                                : ADDR_W'($urandom);
                n = (a == A_FIFO_DATA) ? $urandom_range(1, 20) : $urandom_range(1, 6);
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(7, 14);
                run_session(1'($urandom), a, n);
                if ($urandom_range(0, 9) != 0)
                    cs_release();
            end
            else
                put_event(1'($urandom), 8'($urandom), 1'($urandom));
        end

        gaps_on = 1'b0;
        drain_answers();
        repeat (8) @(posedge clk);
        if (model.miso_pending.size() != 0)
        begin
            $display("%0t: %0d expected answers never arrived", $time,
                     model.miso_pending.size());
            model.errors++;
        end
        $display("Run covered %0d byte transfers and %0d chip-select changes,",
                 model.byte_count, model.cs_count);
        $display("with %0d answers compared and %0d power resets taken.",
                 model.answers_seen, model.power_resets);
        if (model.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: cycle limit reached", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
